@@ design/standard_score_normalizer_core_macros.svh @@
// Assertion macros shared by the standard score normalizer RTL.
`ifndef STANDARD_SCORE_NORMALIZER_CORE_MACROS_SVH
`define STANDARD_SCORE_NORMALIZER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SSN_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SSN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ssn_pkg.sv @@
// Package: widths, codes, state type and divider request for the normalizer.
package ssn_pkg;

   localparam int MAX_FEATURES_DEF   = 64;
   localparam int ROW_COUNT_BITS_DEF = 16;

   localparam int MODE_W   = 2;
   localparam int FEAT_W   = 6;
   localparam int VALUE_W  = 16;
   localparam int SCALED_W = 32;
   localparam int STATUS_W = 2;
   localparam int NF_W     = 7;

   localparam int SUM_W  = 32;
   localparam int SQ_W   = 48;
   localparam int MEAN_W = 24;
   localparam int DEV_W  = 24;

   localparam int DIV_NUM_W = 80;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 7;

   localparam int SQRT_W     = 64;
   localparam int ROOT_W     = 32;
   localparam int SQRT_STEPS = 32;
   localparam int SQRT_CNT_W = 6;

   localparam logic [DEV_W-1:0] ONE_Q8_16 = 24'h010000;

   localparam logic [MODE_W-1:0] MODE_BEGIN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIT    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;
   localparam logic [MODE_W-1:0] MODE_XFORM  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_ROWS = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIT_WB,
      ST_XF_DIFF,
      ST_XF_LOAD,
      ST_XF_DIV,
      ST_FIN_RD,
      ST_FIN_MUL1,
      ST_FIN_MUL2,
      ST_FIN_NS,
      ST_FIN_SUB,
      ST_FIN_MDIV,
      ST_FIN_SDIV,
      ST_FIN_SQRT,
      ST_FIN_ZERO
   } ssn_state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [DIV_NUM_W-1:0] numer;
      logic [DIV_DEN_W-1:0] denom;
   } ssn_div_req_type;

endpackage

@@ design/standard_score_normalizer_core.sv @@
// Top level: per-feature z-score scaler with statistics held in two memories.
//
//  channel   | ports                                       | handshake
//  ----------+---------------------------------------------+-------------------------
//  request   | req_mode, req_feature, req_value            | start high, busy low
//  result    | rsp_scaled, rsp_status                      | rsp_valid, one cycle
//  register  | csr_wdata (num_features)                    | csr_we
//
//  Begin and ignored requests: result in the cycle after acceptance, busy stays low.
//  Fit: read-modify-write of the sum memory; busy while the write-back is pending.
//  Transform: runs the 42-step divider.
//  Finish: per feature in use, 40- and 80-step divides and a 32-step square root;
//  with zero rows, each feature in use gets mean zero and deviation one.
//  Synchronous reset clears control state; the results cannot be stalled.
`include "standard_score_normalizer_core_macros.svh"

module standard_score_normalizer_core #(
   parameter int MAX_FEATURES   = ssn_pkg::MAX_FEATURES_DEF,
   parameter int ROW_COUNT_BITS = ssn_pkg::ROW_COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [ssn_pkg::MODE_W-1:0]   req_mode,
   input  logic        [ssn_pkg::FEAT_W-1:0]   req_feature,
   input  logic signed [ssn_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic signed [ssn_pkg::SCALED_W-1:0] rsp_scaled,
   output logic        [ssn_pkg::STATUS_W-1:0] rsp_status,
   input  logic                                csr_we,
   input  logic        [ssn_pkg::NF_W-1:0]     csr_wdata
);

   localparam int IDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int RCB    = ROW_COUNT_BITS;
   localparam int PL_W   = RCB + 24;
   localparam int NSQ_W  = 2 * RCB;
   localparam int SREC_W = ssn_pkg::SUM_W + ssn_pkg::SQ_W;
   localparam int TREC_W = ssn_pkg::MEAN_W + ssn_pkg::DEV_W;
   localparam int CMP_W  = 12;

   // memories
   logic [SREC_W-1:0] sum_mem  [MAX_FEATURES];
   logic [TREC_W-1:0] stat_mem [MAX_FEATURES];

   logic [SREC_W-1:0] sum_rd_ff;
   logic              sum_rv_ff;
   logic [TREC_W-1:0] stat_rd_ff;
   logic              stat_rv_ff;

   logic [IDX_W-1:0]  sum_raddr;
   logic              sum_we;
   logic [IDX_W-1:0]  sum_waddr;
   logic [SREC_W-1:0] sum_wdata;
   logic              stat_we;
   logic [IDX_W-1:0]  stat_waddr;
   logic [TREC_W-1:0] stat_wdata;

   // control state
   ssn_pkg::ssn_state_type state_ff, state_in;
   logic [ssn_pkg::NF_W-1:0] num_features_ff, num_features_in;
   logic [RCB-1:0]           row_count_ff, row_count_in;
   logic                     fitted_ff, fitted_in;
   logic [MAX_FEATURES-1:0]  sum_vld_ff, sum_vld_in;
   logic [MAX_FEATURES-1:0]  stat_vld_ff, stat_vld_in;
   logic [ssn_pkg::NF_W-1:0] fcnt_ff, fcnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [ssn_pkg::SCALED_W-1:0] rsp_scaled_ff, rsp_scaled_in;
   logic [ssn_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]                    req_idx_ff, req_idx_in;
   logic                                req_last_ff, req_last_in;
   logic signed [ssn_pkg::VALUE_W-1:0]  x_ff, x_in;
   logic [31:0]                         xsq_ff, xsq_in;
   logic [ssn_pkg::SUM_W-1:0]           smag_ff, smag_in;
   logic                                sneg_ff, sneg_in;
   logic [ssn_pkg::SQ_W-1:0]            sq_ff, sq_in;
   logic [PL_W-1:0]                     plo_ff, plo_in;
   logic [PL_W-1:0]                     phi_ff, phi_in;
   logic [63:0]                         s2_ff, s2_in;
   logic [NSQ_W-1:0]                    nsq_ff, nsq_in;
   logic [63:0]                         ns_ff, ns_in;
   logic [63:0]                         a_ff, a_in;
   logic [ssn_pkg::MEAN_W-1:0]          mean_ff, mean_in;
   logic [24:0]                         xmag_ff, xmag_in;
   logic                                xneg_ff, xneg_in;
   logic [ssn_pkg::DEV_W-1:0]           dv_ff, dv_in;

   // combinational helpers
   logic [ssn_pkg::NF_W-1:0]   nf;
   logic                       feat_bad;
   logic                       feat_last;
   logic                       fcnt_last;
   logic                       accept;
   logic [IDX_W-1:0]           feat_idx;
   logic [IDX_W-1:0]           fcnt_idx;
   logic [SREC_W-1:0]          sum_q;
   logic signed [ssn_pkg::SUM_W-1:0] sum_s;
   logic [ssn_pkg::SQ_W-1:0]   sq_q;
   logic [ssn_pkg::MEAN_W-1:0] mean_q;
   logic [ssn_pkg::DEV_W-1:0]  dev_q;
   logic signed [32:0]         sum_new;
   logic [ssn_pkg::SQ_W:0]     sq_new;
   logic signed [24:0]         diff;
   logic [39:0]                q_mean;
   logic [41:0]                q_xf;
   logic [ssn_pkg::DEV_W-1:0]  dev_new;
   logic [31:0]                xsq_ext;

   ssn_pkg::ssn_div_req_type       div_req;
   logic                           div_done;
   logic [ssn_pkg::DIV_NUM_W-1:0]  div_quo;
   logic                           sqrt_start;
   logic [ssn_pkg::SQRT_W-1:0]     sqrt_rad;
   logic                           sqrt_done;
   logic [ssn_pkg::ROOT_W-1:0]     sqrt_root;

   ssn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   ssn_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // clamp the register to 1..MAX_FEATURES
   always_comb begin
      if (num_features_ff == '0) begin
         nf = ssn_pkg::NF_W'(1);
      end else if (CMP_W'(num_features_ff) > CMP_W'(MAX_FEATURES)) begin
         nf = ssn_pkg::NF_W'(MAX_FEATURES);
      end else begin
         nf = num_features_ff;
      end
   end

   assign feat_bad  = {1'b0, req_feature} >= nf;
   assign feat_last = {1'b0, req_feature} == (nf - 1'b1);
   assign fcnt_last = fcnt_ff == (nf - 1'b1);
   assign accept    = start && (state_ff == ssn_pkg::ST_IDLE);
   assign feat_idx  = IDX_W'(req_feature);
   assign fcnt_idx  = IDX_W'(fcnt_ff);
   assign sum_raddr = (state_ff == ssn_pkg::ST_IDLE) ? feat_idx : fcnt_idx;

   // entries never written read as their reset values
   assign sum_q  = sum_rv_ff ? sum_rd_ff : '0;
   assign sum_s  = sum_q[SREC_W-1:ssn_pkg::SQ_W];
   assign sq_q   = sum_q[ssn_pkg::SQ_W-1:0];
   assign mean_q = stat_rv_ff ? stat_rd_ff[TREC_W-1:ssn_pkg::DEV_W] : '0;
   assign dev_q  = stat_rv_ff ? stat_rd_ff[ssn_pkg::DEV_W-1:0] : ssn_pkg::ONE_Q8_16;

   assign xsq_ext = {{16{req_value[15]}}, req_value};
   assign sum_new = {sum_s[31], sum_s} + {{17{x_ff[15]}}, x_ff};
   assign sq_new  = {1'b0, sq_q} + (ssn_pkg::SQ_W + 1)'(xsq_ff);
   assign diff    = {x_ff[15], x_ff, 8'b0} - {mean_q[23], mean_q};
   assign q_mean  = div_quo[39:0];
   assign q_xf    = div_quo[41:0];

   always_comb begin
      if (sqrt_root > 32'h00FF_FFFF) begin
         dev_new = 24'hFF_FFFF;
      end else if (sqrt_root == '0) begin
         dev_new = ssn_pkg::ONE_Q8_16;
      end else begin
         dev_new = sqrt_root[ssn_pkg::DEV_W-1:0];
      end
   end

   always_comb begin
      state_in        = state_ff;
      num_features_in = csr_we ? csr_wdata : num_features_ff;
      row_count_in    = row_count_ff;
      fitted_in       = fitted_ff;
      sum_vld_in      = sum_vld_ff;
      stat_vld_in     = stat_vld_ff;
      fcnt_in         = fcnt_ff;
      rsp_valid_in    = 1'b0;
      rsp_scaled_in   = rsp_scaled_ff;
      rsp_status_in   = rsp_status_ff;
      req_idx_in      = req_idx_ff;
      req_last_in     = req_last_ff;
      x_in            = x_ff;
      xsq_in          = xsq_ff;
      smag_in         = smag_ff;
      sneg_in         = sneg_ff;
      sq_in           = sq_ff;
      plo_in          = plo_ff;
      phi_in          = phi_ff;
      s2_in           = s2_ff;
      nsq_in          = nsq_ff;
      ns_in           = ns_ff;
      a_in            = a_ff;
      mean_in         = mean_ff;
      xmag_in         = xmag_ff;
      xneg_in         = xneg_ff;
      dv_in           = dv_ff;
      sum_we          = 1'b0;
      sum_waddr       = req_idx_ff;
      sum_wdata       = '0;
      stat_we         = 1'b0;
      stat_waddr      = fcnt_idx;
      stat_wdata      = '0;
      div_req         = '0;
      sqrt_start      = 1'b0;
      sqrt_rad        = div_quo[ssn_pkg::SQRT_W-1:0];

      unique case (state_ff)
         ssn_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  ssn_pkg::MODE_BEGIN: begin
                     sum_vld_in    = '0;
                     row_count_in  = '0;
                     fitted_in     = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_scaled_in = '0;
                     rsp_status_in = ssn_pkg::STATUS_OK;
                  end
                  ssn_pkg::MODE_FIT: begin
                     if (feat_bad || (&row_count_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_scaled_in = '0;
                        rsp_status_in = ssn_pkg::STATUS_IGNORED;
                     end else begin
                        req_idx_in  = feat_idx;
                        req_last_in = feat_last;
                        x_in        = req_value;
                        xsq_in      = xsq_ext * xsq_ext;
                        state_in    = ssn_pkg::ST_FIT_WB;
                     end
                  end
                  ssn_pkg::MODE_FINISH: begin
                     fcnt_in  = '0;
                     state_in = (row_count_ff == '0) ? ssn_pkg::ST_FIN_ZERO
                                                     : ssn_pkg::ST_FIN_RD;
                  end
                  ssn_pkg::MODE_XFORM: begin
                     if (feat_bad || !fitted_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_scaled_in = '0;
                        rsp_status_in = ssn_pkg::STATUS_IGNORED;
                     end else begin
                        x_in     = req_value;
                        state_in = ssn_pkg::ST_XF_DIFF;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ssn_pkg::ST_FIT_WB: begin
            sum_we = 1'b1;
            sum_wdata[SREC_W-1:ssn_pkg::SQ_W] =
               (sum_new[32] != sum_new[31]) ? (sum_new[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                            : sum_new[31:0];
            sum_wdata[ssn_pkg::SQ_W-1:0] =
               sq_new[ssn_pkg::SQ_W] ? {ssn_pkg::SQ_W{1'b1}} : sq_new[ssn_pkg::SQ_W-1:0];
            sum_vld_in[req_idx_ff] = 1'b1;
            if (req_last_ff) begin
               row_count_in = row_count_ff + 1'b1;
            end
            rsp_valid_in  = 1'b1;
            rsp_scaled_in = '0;
            rsp_status_in = ssn_pkg::STATUS_OK;
            state_in      = ssn_pkg::ST_IDLE;
         end

         ssn_pkg::ST_XF_DIFF: begin
            xneg_in  = diff[24];
            xmag_in  = diff[24] ? 25'(-diff) : diff;
            dv_in    = (dev_q == '0) ? ssn_pkg::ONE_Q8_16 : dev_q;
            state_in = ssn_pkg::ST_XF_LOAD;
         end

         ssn_pkg::ST_XF_LOAD: begin
            div_req.start = 1'b1;
            div_req.steps = ssn_pkg::DIV_CNT_W'(42);
            div_req.numer = {(42'(xmag_ff) << 16) + 42'(dv_ff >> 1), 38'b0};
            div_req.denom = ssn_pkg::DIV_DEN_W'(dv_ff);
            state_in      = ssn_pkg::ST_XF_DIV;
         end

         ssn_pkg::ST_XF_DIV: begin
            if (div_done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ssn_pkg::STATUS_OK;
               if (xneg_ff) begin
                  rsp_scaled_in = (q_xf > 42'h0_8000_0000) ? 32'sh8000_0000
                                                          : 32'(42'd0 - q_xf);
               end else begin
                  rsp_scaled_in = (q_xf > 42'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                          : q_xf[31:0];
               end
               state_in = ssn_pkg::ST_IDLE;
            end
         end

         ssn_pkg::ST_FIN_RD: begin
            state_in = ssn_pkg::ST_FIN_MUL1;
         end

         ssn_pkg::ST_FIN_MUL1: begin
            sneg_in  = sum_s[31];
            smag_in  = sum_s[31] ? 32'(-sum_s) : sum_s;
            sq_in    = sq_q;
            plo_in   = PL_W'(row_count_ff) * PL_W'(sq_q[23:0]);
            state_in = ssn_pkg::ST_FIN_MUL2;
         end

         ssn_pkg::ST_FIN_MUL2: begin
            s2_in    = 64'(smag_ff) * 64'(smag_ff);
            phi_in   = PL_W'(row_count_ff) * PL_W'(sq_ff[47:24]);
            nsq_in   = NSQ_W'(row_count_ff) * NSQ_W'(row_count_ff);
            state_in = ssn_pkg::ST_FIN_NS;
         end

         ssn_pkg::ST_FIN_NS: begin
            ns_in    = (64'(phi_ff) << 24) + 64'(plo_ff);
            state_in = ssn_pkg::ST_FIN_SUB;
         end

         ssn_pkg::ST_FIN_SUB: begin
            // a negative spread counts as zero
            a_in = (ns_ff > s2_ff) ? ns_ff - s2_ff : '0;
            div_req.start = 1'b1;
            div_req.steps = ssn_pkg::DIV_CNT_W'(40);
            div_req.numer = {{smag_ff, 8'b0} + 40'(row_count_ff >> 1), 40'b0};
            div_req.denom = ssn_pkg::DIV_DEN_W'(row_count_ff);
            state_in      = ssn_pkg::ST_FIN_MDIV;
         end

         ssn_pkg::ST_FIN_MDIV: begin
            if (div_done) begin
               if (sneg_ff) begin
                  mean_in = (q_mean > 40'h80_0000) ? 24'h80_0000 : 24'(40'd0 - q_mean);
               end else begin
                  mean_in = (q_mean > 40'h7F_FFFF) ? 24'h7F_FFFF : q_mean[23:0];
               end
               // spread * 2^16 / n^2 in one divide
               div_req.start = 1'b1;
               div_req.steps = ssn_pkg::DIV_CNT_W'(ssn_pkg::DIV_NUM_W);
               div_req.numer = {a_ff, 16'b0};
               div_req.denom = ssn_pkg::DIV_DEN_W'(nsq_ff);
               state_in      = ssn_pkg::ST_FIN_SDIV;
            end
         end

         ssn_pkg::ST_FIN_SDIV: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = ssn_pkg::ST_FIN_SQRT;
            end
         end

         ssn_pkg::ST_FIN_SQRT: begin
            if (sqrt_done) begin
               stat_we                = 1'b1;
               stat_wdata             = {mean_ff, dev_new};
               stat_vld_in[fcnt_idx]  = 1'b1;
               if (fcnt_last) begin
                  fitted_in     = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_scaled_in = '0;
                  rsp_status_in = ssn_pkg::STATUS_OK;
                  state_in      = ssn_pkg::ST_IDLE;
               end else begin
                  fcnt_in  = fcnt_ff + 1'b1;
                  state_in = ssn_pkg::ST_FIN_RD;
               end
            end
         end

         ssn_pkg::ST_FIN_ZERO: begin
            stat_we               = 1'b1;
            stat_wdata            = {{ssn_pkg::MEAN_W{1'b0}}, ssn_pkg::ONE_Q8_16};
            stat_vld_in[fcnt_idx] = 1'b1;
            if (fcnt_last) begin
               fitted_in     = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_scaled_in = '0;
               rsp_status_in = ssn_pkg::STATUS_ZERO_ROWS;
               state_in      = ssn_pkg::ST_IDLE;
            end else begin
               fcnt_in = fcnt_ff + 1'b1;
            end
         end

         default: begin
            state_in = ssn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ssn_pkg::ST_IDLE;
         num_features_ff <= ssn_pkg::NF_W'(1);
         row_count_ff    <= '0;
         fitted_ff       <= 1'b0;
         sum_vld_ff      <= '0;
         stat_vld_ff     <= '0;
         fcnt_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         num_features_ff <= num_features_in;
         row_count_ff    <= row_count_in;
         fitted_ff       <= fitted_in;
         sum_vld_ff      <= sum_vld_in;
         stat_vld_ff     <= stat_vld_in;
         fcnt_ff         <= fcnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_status_ff <= rsp_status_in;
      req_idx_ff    <= req_idx_in;
      req_last_ff   <= req_last_in;
      x_ff          <= x_in;
      xsq_ff        <= xsq_in;
      smag_ff       <= smag_in;
      sneg_ff       <= sneg_in;
      sq_ff         <= sq_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      s2_ff         <= s2_in;
      nsq_ff        <= nsq_in;
      ns_ff         <= ns_in;
      a_ff          <= a_in;
      mean_ff       <= mean_in;
      xmag_ff       <= xmag_in;
      xneg_ff       <= xneg_in;
      dv_ff         <= dv_in;
   end

   // sum memory: one read port, one write port
   always_ff @(posedge clock) begin
      sum_rd_ff <= sum_mem[sum_raddr];
      sum_rv_ff <= sum_vld_ff[sum_raddr];
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
   end

   // statistics memory
   always_ff @(posedge clock) begin
      stat_rd_ff <= stat_mem[feat_idx];
      stat_rv_ff <= stat_vld_ff[feat_idx];
      if (stat_we) begin
         stat_mem[stat_waddr] <= stat_wdata;
      end
   end

   assign busy       = state_ff != ssn_pkg::ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_scaled = rsp_scaled_ff;
   assign rsp_status = rsp_status_ff;

   `SSN_ASSERT_NEXT(a_accept_answers, (start && !busy), (rsp_valid || busy),
      "accepted request neither answered nor in progress")
   `SSN_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy,
      "result strobe while a request is still in progress")
   `SSN_ASSERT_SAME(a_div_idle_start, div_req.start,
      (state_ff == ssn_pkg::ST_XF_LOAD || state_ff == ssn_pkg::ST_FIN_SUB ||
       div_done), "divider started while running")
   `SSN_ASSERT_SAME(a_stat_write_finish, stat_we,
      (state_ff == ssn_pkg::ST_FIN_SQRT || state_ff == ssn_pkg::ST_FIN_ZERO),
      "statistics written outside finish")
   `SSN_ASSERT_NEXT(a_zero_rows_fitted,
      (rsp_valid_in && rsp_status_in == ssn_pkg::STATUS_ZERO_ROWS), fitted_ff,
      "zero-row finish did not mark the block fitted")

endmodule

@@ design/ssn_div.sv @@
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
module ssn_div (
   input  logic                            clock,
   input  logic                            reset,
   input  ssn_pkg::ssn_div_req_type        req,
   output logic                            done,
   output logic [ssn_pkg::DIV_NUM_W-1:0]   quotient
);

   logic [ssn_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic [ssn_pkg::DIV_DEN_W:0]   rem_ff, rem_in;
   logic [ssn_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [ssn_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [ssn_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [ssn_pkg::DIV_DEN_W:0]   trial;
   logic                          fits;

   always_comb begin
      trial = {rem_ff[ssn_pkg::DIV_DEN_W-1:0], num_ff[ssn_pkg::DIV_NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         cnt_in = req.steps;
         rem_in = '0;
         num_in = req.numer;
         quo_in = '0;
         den_in = req.denom;
      end else if (cnt_ff != '0) begin
         rem_in = fits ? trial - {1'b0, den_ff} : trial;
         num_in = {num_ff[ssn_pkg::DIV_NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[ssn_pkg::DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == ssn_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/ssn_isqrt.sv @@
// Integer square root, two radicand bits per cycle.
module ssn_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ssn_pkg::SQRT_W-1:0]    radicand,
   output logic                          done,
   output logic [ssn_pkg::ROOT_W-1:0]    root
);

   logic [ssn_pkg::SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [ssn_pkg::SQRT_W-1:0]     x_ff, x_in;
   logic [ssn_pkg::SQRT_W-1:0]     r_ff, r_in;
   logic [ssn_pkg::SQRT_W-1:0]     bit_ff, bit_in;
   logic [ssn_pkg::SQRT_W-1:0]     trial;

   always_comb begin
      trial   = r_ff + bit_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         cnt_in = ssn_pkg::SQRT_CNT_W'(ssn_pkg::SQRT_STEPS);
         x_in   = radicand;
         r_in   = '0;
         bit_in = {2'b01, {(ssn_pkg::SQRT_W-2){1'b0}}};
      end else if (cnt_ff != '0) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == ssn_pkg::SQRT_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[ssn_pkg::ROOT_W-1:0];

endmodule
